>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Widths, calendar constants and reciprocal multipliers for the converter.
// ----------------------------------------------------------------------------
package jsc_pkg;

	// Field widths
	localparam int SECS_W   = 39;
	localparam int YEAR_W   = 15;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int WDAY_W   = 3;
	localparam int JDN_W    = 23;

	// Last supported instant, 9999-12-31 23:59:59.
	localparam logic [SECS_W-1:0] MAX_SECONDS = 39'd464269103999;

	// Calendar constants of the day-number algorithm.
	localparam logic [JDN_W-1:0] JDN_OFFSET = 23'd32044;
	localparam int D675      = 675;     // 86400 / 128
	localparam int D146097   = 146097;  // days in 400 years
	localparam int D1461     = 1461;    // days in 4 years
	localparam int D153      = 153;     // days in 5 months of the shifted year
	localparam int D3600     = 3600;
	localparam int D60       = 60;
	localparam int D25       = 25;
	localparam int D7        = 7;
	localparam int CENTURY   = 100;
	localparam int YEAR_BASE = 4800;
	localparam int MONTH_WRAP = 10;     // shifted month index of January

	// Exact reciprocals: q = (x * M) >> K with M = ceil(2^K / D) and
	// K = (bits of x) + ceil(log2 D).
	localparam int K675  = 42;
	localparam int K146097 = 43;
	localparam int K1461 = 29;
	localparam int K153  = 19;
	localparam int K7    = 26;
	localparam int K3600 = 29;
	localparam int K60   = 18;
	localparam int K25   = 20;

	localparam logic [32:0] M675 =
		33'(((64'd1 << K675) + 64'(D675) - 64'd1) / 64'(D675));
	localparam logic [25:0] M146097 =
		26'(((64'd1 << K146097) + 64'(D146097) - 64'd1) / 64'(D146097));
	localparam logic [18:0] M1461 =
		19'(((64'd1 << K1461) + 64'(D1461) - 64'd1) / 64'(D1461));
	localparam logic [11:0] M153 =
		12'(((64'd1 << K153) + 64'(D153) - 64'd1) / 64'(D153));
	localparam logic [23:0] M7 =
		24'(((64'd1 << K7) + 64'(D7) - 64'd1) / 64'(D7));
	localparam logic [17:0] M3600 =
		18'(((64'd1 << K3600) + 64'(D3600) - 64'd1) / 64'(D3600));
	localparam logic [12:0] M60 =
		13'(((64'd1 << K60) + 64'(D60) - 64'd1) / 64'(D60));
	localparam logic [15:0] M25 =
		16'(((64'd1 << K25) + 64'(D25) - 64'd1) / 64'(D25));

	// Day offset of each month in the March-based year: (153 * m + 2) / 5.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/jsc_in_if.sv
// ----------------------------------------------------------------------------
// jsc_in_if
// Request channel carrying a timestamp in seconds since Julian day zero.
// ----------------------------------------------------------------------------
interface jsc_in_if;
	logic                          valid;
	logic                          ready;
	logic [jsc_pkg::SECS_W-1:0]    julian_seconds;

	modport source(output valid, output julian_seconds, input ready);
	modport sink(input valid, input julian_seconds, output ready);
endinterface

>>> rtl/jsc_out_if.sv
// ----------------------------------------------------------------------------
// jsc_out_if
// Result channel carrying the calendar fields of one timestamp.
// ----------------------------------------------------------------------------
interface jsc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [jsc_pkg::YEAR_W-1:0]  year_out;
	logic [jsc_pkg::MONTH_W-1:0]        month_out;
	logic [jsc_pkg::DAY_W-1:0]          day_out;
	logic [jsc_pkg::HOUR_W-1:0]         hour_out;
	logic [jsc_pkg::MINUTE_W-1:0]       minute_out;
	logic [jsc_pkg::SECOND_W-1:0]       second_out;
	logic [jsc_pkg::WDAY_W-1:0]         weekday;
	logic                               leap_flag;
	logic                               out_of_range;

	modport source(output valid, output year_out, output month_out, output day_out,
		output hour_out, output minute_out, output second_out, output weekday,
		output leap_flag, output out_of_range, input ready);
	modport sink(input valid, input year_out, input month_out, input day_out,
		input hour_out, input minute_out, input second_out, input weekday,
		input leap_flag, input out_of_range, output ready);
endinterface

>>> rtl/julian_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// julian_seconds_to_calendar
// Pipelined conversion of Julian seconds to proleptic Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the seconds channel carries a count of seconds since the
//   start of Julian day zero. Each request yields exactly one result on the
//   calendar channel: year (no year zero, 1 BC is -1), month, day, hour,
//   minute, second, weekday (1 Monday to 7 Sunday), a leap-year flag and an
//   out-of-range flag. Past 9999-12-31 23:59:59 only out_of_range is set and
//   every other field reads zero.
//   An accepted request loads into stage 1 and passes through all ten
//   register stages to the result channel. The pipeline takes one request
//   per cycle while ready is high; its depth is set by the chain
//   of constant divisions, each done as a reciprocal multiply in one stage
//   and a multiply-back in the next.
//   Every stage has its own valid bit and advances when it is empty or when
//   the stage after it advances, so bubbles close up while the receiver
//   stalls and ready falls only when all ten stages hold a request.
//   Reset clears the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module julian_seconds_to_calendar (
	input  logic         clk,
	input  logic         arst_n,
	jsc_in_if.sink       seconds,
	jsc_out_if.source    calendar
);

	// ------------------------------------------------------------------------
	// Stage handshake. A stage loads when it is empty or its content moves on.
	// ------------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic en_s6, en_s7, en_s8, en_s9, en_s10;

	assign en_s10 = !vld_s10 || calendar.ready;
	assign en_s9  = !vld_s9  || en_s10;
	assign en_s8  = !vld_s8  || en_s9;
	assign en_s7  = !vld_s7  || en_s8;
	assign en_s6  = !vld_s6  || en_s7;
	assign en_s5  = !vld_s5  || en_s6;
	assign en_s4  = !vld_s4  || en_s5;
	assign en_s3  = !vld_s3  || en_s4;
	assign en_s2  = !vld_s2  || en_s3;
	assign en_s1  = !vld_s1  || en_s2;

	assign seconds.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= seconds.valid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_s4)  vld_s4  <= vld_s3;
			if (en_s5)  vld_s5  <= vld_s4;
			if (en_s6)  vld_s6  <= vld_s5;
			if (en_s7)  vld_s7  <= vld_s6;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: range check and the reciprocal multiply for the day count.
	// 86400 = 128 * 675, so the low seven bits pass straight through and the
	// upper 32 bits are divided by 675.
	// ------------------------------------------------------------------------
	logic [38:0] secs_s1;
	logic [64:0] p675_s1;
	logic        oor_s1;
	logic [64:0] p675_n;
	logic        oor_n;

	assign p675_n = 65'(seconds.julian_seconds[38:7]) * 65'(jsc_pkg::M675);
	assign oor_n  = seconds.julian_seconds > jsc_pkg::MAX_SECONDS;

	// ------------------------------------------------------------------------
	// Stage 2: whole days and the seconds into the day.
	// ------------------------------------------------------------------------
	logic [22:0] jday_s2;
	logic [16:0] rem_s2;
	logic        oor_s2;
	logic [22:0] jday_n;
	logic [31:0] hi_n;

	assign jday_n = p675_s1[64:42];
	assign hi_n   = secs_s1[38:7] - 32'(32'(jday_n) * 32'(jsc_pkg::D675));

	// ------------------------------------------------------------------------
	// Stage 3: shifted day number and three parallel reciprocal multiplies:
	// centuries, day of week and hour.
	// ------------------------------------------------------------------------
	logic [22:0] a_s3;
	logic [22:0] jday_s3;
	logic [16:0] rem_s3;
	logic [50:0] pb_s3;
	logic [46:0] pw_s3;
	logic [33:0] ph_s3;
	logic        oor_s3;
	logic [22:0] a_n;

	assign a_n = jday_s2 + jsc_pkg::JDN_OFFSET;

	// ------------------------------------------------------------------------
	// Stage 4: century count b and day within the century c, weekday
	// remainder, hour and the seconds into the hour.
	// ------------------------------------------------------------------------
	logic [7:0]  b_s4;
	logic [15:0] c_s4;
	logic [2:0]  wd_s4;
	logic [4:0]  hour_s4;
	logic [11:0] rem2_s4;
	logic        oor_s4;
	logic [7:0]  b_n;
	logic [24:0] bq_n;
	logic [22:0] cq_n;
	logic [20:0] q7_n;
	logic [22:0] wr_n;
	logic [4:0]  hour_n;
	logic [16:0] r2_n;

	assign b_n    = pb_s3[50:43];
	assign bq_n   = 25'(b_n) * 25'(jsc_pkg::D146097);
	assign cq_n   = a_s3 - bq_n[24:2];
	assign q7_n   = pw_s3[46:26];
	assign wr_n   = jday_s3 - 23'(23'(q7_n) * 23'(jsc_pkg::D7));
	assign hour_n = ph_s3[33:29];
	assign r2_n   = rem_s3 - 17'(17'(hour_n) * 17'(jsc_pkg::D3600));

	// ------------------------------------------------------------------------
	// Stage 5: reciprocal multiplies for the year within the century and the
	// minute.
	// ------------------------------------------------------------------------
	logic [7:0]  b_s5;
	logic [15:0] c_s5;
	logic [35:0] pd_s5;
	logic [2:0]  wd_s5;
	logic [4:0]  hour_s5;
	logic [11:0] rem2_s5;
	logic [23:0] pmin_s5;
	logic        oor_s5;

	// ------------------------------------------------------------------------
	// Stage 6: year within the century d, day within that year e, minute and
	// second.
	// ------------------------------------------------------------------------
	logic [7:0]  b_s6;
	logic [6:0]  d_s6;
	logic [8:0]  e_s6;
	logic [2:0]  wd_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  min_s6;
	logic [5:0]  sec_s6;
	logic        oor_s6;
	logic [6:0]  d_n;
	logic [17:0] dq_n;
	logic [15:0] eq_n;
	logic [5:0]  min_n;
	logic [11:0] sq_n;

	assign d_n   = pd_s5[35:29];
	assign dq_n  = 18'(d_n) * 18'(jsc_pkg::D1461);
	assign eq_n  = c_s5 - dq_n[17:2];
	assign min_n = pmin_s5[23:18];
	assign sq_n  = rem2_s5 - 12'(12'(min_n) * 12'(jsc_pkg::D60));

	// ------------------------------------------------------------------------
	// Stage 7: reciprocal multiply for the month of the March-based year.
	// ------------------------------------------------------------------------
	logic [7:0]  b_s7;
	logic [6:0]  d_s7;
	logic [8:0]  e_s7;
	logic [22:0] pm_s7;
	logic [2:0]  wd_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7;
	logic [5:0]  sec_s7;
	logic        oor_s7;
	logic [10:0] x5_n;

	assign x5_n = 11'(11'(e_s6) * 11'd5 + 11'd2);

	// ------------------------------------------------------------------------
	// Stage 8: month, day of month and signed year. Years up to zero move
	// down by one, since there is no year zero.
	// ------------------------------------------------------------------------
	logic signed [15:0] year_s8;
	logic [3:0]  mon_s8;
	logic [4:0]  mday_s8;
	logic [2:0]  wd_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  min_s8;
	logic [5:0]  sec_s8;
	logic        oor_s8;
	logic [3:0]  m_n;
	logic [8:0]  mdq_n;
	logic        jan_feb_n;
	logic [3:0]  mon_n;
	logic signed [15:0] yraw_n;
	logic signed [15:0] year_n;

	assign m_n       = pm_s7[22:19];
	assign mdq_n     = e_s7 - jsc_pkg::month_start(m_n) + 9'd1;
	assign jan_feb_n = m_n >= 4'(jsc_pkg::MONTH_WRAP);
	assign mon_n     = jan_feb_n ? m_n - 4'(jsc_pkg::MONTH_WRAP - 1) : m_n + 4'd3;
	assign yraw_n    = $signed(16'(16'(b_s7) * 16'(jsc_pkg::CENTURY) + 16'(d_s7)
		+ 16'(jan_feb_n))) - $signed(16'(jsc_pkg::YEAR_BASE));
	assign year_n    = (yraw_n <= 16'sd0) ? yraw_n - 16'sd1 : yraw_n;

	// ------------------------------------------------------------------------
	// Stage 9: magnitude of the year and its reciprocal multiply by 1/25.
	// ------------------------------------------------------------------------
	logic signed [14:0] year_s9;
	logic [14:0] mag_s9;
	logic [30:0] py_s9;
	logic [3:0]  mon_s9;
	logic [4:0]  mday_s9;
	logic [2:0]  wd_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  min_s9;
	logic [5:0]  sec_s9;
	logic        oor_s9;
	logic [14:0] mag_n;

	assign mag_n = (year_s8 < 16'sd0) ? 15'(-year_s8) : 15'(year_s8);

	// ------------------------------------------------------------------------
	// Stage 10: leap test and output register. A year divides by 100 when it
	// divides by 4 and 25, and by 400 when it divides by 16 and 25.
	// ------------------------------------------------------------------------
	logic signed [14:0] year_s10;
	logic [3:0]  mon_s10;
	logic [4:0]  mday_s10;
	logic [4:0]  hour_s10;
	logic [5:0]  min_s10;
	logic [5:0]  sec_s10;
	logic [2:0]  wday_s10;
	logic        leap_s10;
	logic        oor_s10;
	logic [10:0] q25_n;
	logic        div25_n;
	logic        leap_n;

	assign q25_n   = py_s9[30:20];
	assign div25_n = 15'(15'(q25_n) * 15'(jsc_pkg::D25)) == mag_s9;
	assign leap_n  = (mag_s9[1:0] == 2'd0) && (!div25_n || (mag_s9[3:0] == 4'd0));

	// ------------------------------------------------------------------------
	// Data registers, one enable per stage.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_s1) begin
			secs_s1 <= seconds.julian_seconds;
			p675_s1 <= p675_n;
			oor_s1  <= oor_n;
		end
		if (en_s2) begin
			jday_s2 <= jday_n;
			rem_s2  <= {hi_n[9:0], secs_s1[6:0]};
			oor_s2  <= oor_s1;
		end
		if (en_s3) begin
			a_s3    <= a_n;
			jday_s3 <= jday_s2;
			rem_s3  <= rem_s2;
			pb_s3   <= 51'({a_n, 2'b11}) * 51'(jsc_pkg::M146097);
			pw_s3   <= 47'(jday_s2) * 47'(jsc_pkg::M7);
			ph_s3   <= 34'(rem_s2) * 34'(jsc_pkg::M3600);
			oor_s3  <= oor_s2;
		end
		if (en_s4) begin
			b_s4    <= b_n;
			c_s4    <= cq_n[15:0];
			wd_s4   <= wr_n[2:0];
			hour_s4 <= hour_n;
			rem2_s4 <= r2_n[11:0];
			oor_s4  <= oor_s3;
		end
		if (en_s5) begin
			b_s5    <= b_s4;
			c_s5    <= c_s4;
			pd_s5   <= 36'({c_s4, 2'b11}) * 36'(jsc_pkg::M1461);
			wd_s5   <= wd_s4;
			hour_s5 <= hour_s4;
			rem2_s5 <= rem2_s4;
			pmin_s5 <= 24'(rem2_s4) * 24'(jsc_pkg::M60);
			oor_s5  <= oor_s4;
		end
		if (en_s6) begin
			b_s6    <= b_s5;
			d_s6    <= d_n;
			e_s6    <= eq_n[8:0];
			wd_s6   <= wd_s5;
			hour_s6 <= hour_s5;
			min_s6  <= min_n;
			sec_s6  <= sq_n[5:0];
			oor_s6  <= oor_s5;
		end
		if (en_s7) begin
			b_s7    <= b_s6;
			d_s7    <= d_s6;
			e_s7    <= e_s6;
			pm_s7   <= 23'(x5_n) * 23'(jsc_pkg::M153);
			wd_s7   <= wd_s6;
			hour_s7 <= hour_s6;
			min_s7  <= min_s6;
			sec_s7  <= sec_s6;
			oor_s7  <= oor_s6;
		end
		if (en_s8) begin
			year_s8 <= year_n;
			mon_s8  <= mon_n;
			mday_s8 <= mdq_n[4:0];
			wd_s8   <= wd_s7;
			hour_s8 <= hour_s7;
			min_s8  <= min_s7;
			sec_s8  <= sec_s7;
			oor_s8  <= oor_s7;
		end
		if (en_s9) begin
			year_s9 <= year_s8[14:0];
			mag_s9  <= mag_n;
			py_s9   <= 31'(mag_n) * 31'(jsc_pkg::M25);
			mon_s9  <= mon_s8;
			mday_s9 <= mday_s8;
			wd_s9   <= wd_s8;
			hour_s9 <= hour_s8;
			min_s9  <= min_s8;
			sec_s9  <= sec_s8;
			oor_s9  <= oor_s8;
		end
		if (en_s10) begin
			// Out-of-range requests report only the flag.
			if (oor_s9) begin
				year_s10 <= '0;
				mon_s10  <= '0;
				mday_s10 <= '0;
				hour_s10 <= '0;
				min_s10  <= '0;
				sec_s10  <= '0;
				wday_s10 <= '0;
				leap_s10 <= 1'b0;
			end else begin
				year_s10 <= year_s9;
				mon_s10  <= mon_s9;
				mday_s10 <= mday_s9;
				hour_s10 <= hour_s9;
				min_s10  <= min_s9;
				sec_s10  <= sec_s9;
				wday_s10 <= wd_s9 + 3'd1;
				leap_s10 <= leap_n;
			end
			oor_s10 <= oor_s9;
		end
	end

	// ------------------------------------------------------------------------
	// Result channel, driven straight from the last stage.
	// ------------------------------------------------------------------------
	assign calendar.valid        = vld_s10;
	assign calendar.year_out     = year_s10;
	assign calendar.month_out    = mon_s10;
	assign calendar.day_out      = mday_s10;
	assign calendar.hour_out     = hour_s10;
	assign calendar.minute_out   = min_s10;
	assign calendar.second_out   = sec_s10;
	assign calendar.weekday      = wday_s10;
	assign calendar.leap_flag    = leap_s10;
	assign calendar.out_of_range = oor_s10;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	// Back-pressure reaches the request side only once every stage is full.
	`ASSERT_IMPLIES(a_ready_full, clk, arst_n, !seconds.ready,
		vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7 && vld_s8
		&& vld_s9 && vld_s10, "ready low while a pipeline stage is empty")

	// An in-range result carries a legal date and time.
	`ASSERT_IMPLIES(a_fields_legal, clk, arst_n, calendar.valid && !calendar.out_of_range,
		calendar.month_out != 4'd0 && calendar.month_out <= 4'd12
		&& calendar.day_out != 5'd0 && calendar.hour_out <= 5'd23
		&& calendar.minute_out <= 6'd59 && calendar.second_out <= 6'd59
		&& calendar.weekday != 3'd0, "in-range result has an illegal field")

	// An out-of-range result carries nothing but the flag.
	`ASSERT_IMPLIES(a_oor_zero, clk, arst_n, calendar.valid && calendar.out_of_range,
		calendar.year_out == 15'sd0 && calendar.month_out == 4'd0
		&& calendar.day_out == 5'd0 && calendar.weekday == 3'd0
		&& !calendar.leap_flag, "out-of-range result has nonzero fields")

	// A request that leaves stage nine shows up as a valid result.
	`ASSERT_NEXT(a_last_stage_load, clk, arst_n, vld_s9 && en_s10,
		calendar.valid, "request lost between stage nine and the output")

endmodule
